// ===== sv/tank_pump_interlock_controller_assert.svh =====
// Assertion macros for the tank pump interlock controller.
// Every macro expects signals named clock and reset in the using module.
`ifndef TANK_PUMP_INTERLOCK_CONTROLLER_ASSERT_SVH
`define TANK_PUMP_INTERLOCK_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define TPIC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpic assertion failed: same-cycle implication");
`define TPIC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpic assertion failed: next-cycle implication");
`else
`define TPIC_ASSERT_SAME(label, ante, cons)
`define TPIC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/tpic_pkg.sv =====
`timescale 1ns / 1ps

package tpic_pkg;

   localparam int TIME_W   = 32;
   localparam int LEVEL_W  = 10;
   localparam int MS_W     = 22;
   localparam int WIN_W    = 27;
   localparam int STARTS_W = 16;
   localparam int OP_W     = 4;
   localparam int MODE_W   = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = WIN_W;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 88;

   // dry run needs a rise of 1 %, overflow releases 5 % below its level
   localparam logic [LEVEL_W:0] RISE_MIN   = 11'd10;
   localparam logic [LEVEL_W:0] OVF_MARGIN = 11'd50;

   localparam logic [LEVEL_W-1:0] UPPER_RST     = 10'd900;
   localparam logic [LEVEL_W-1:0] LOWER_RST     = 10'd200;
   localparam logic [LEVEL_W-1:0] OVERFLOW_RST  = 10'd950;
   localparam logic [LEVEL_W-1:0] MAX_START_RST = 10'd900;
   localparam logic [MS_W-1:0]    MIN_OFF_RST   = 22'd30000;
   localparam logic [MS_W-1:0]    MIN_RUN_RST   = 22'd30000;
   localparam logic [WIN_W-1:0]   WINDOW_RST    = 27'd300000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_UPPER     = 3'd0,
      CSR_LOWER     = 3'd1,
      CSR_OVERFLOW  = 3'd2,
      CSR_MAX_START = 3'd3,
      CSR_MIN_OFF   = 3'd4,
      CSR_MIN_RUN   = 3'd5,
      CSR_WINDOW    = 3'd6
   } csr_addr_type;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE    = 4'd0,
      OP_REQ_ON    = 4'd1,
      OP_REQ_OFF   = 4'd2,
      OP_FORCE_ON  = 4'd3,
      OP_FORCE_OFF = 4'd4,
      OP_TOGGLE    = 4'd5,
      OP_AUTO      = 4'd6,
      OP_MANUAL    = 4'd7,
      OP_OVR_ENTER = 4'd8,
      OP_OVR_EXIT  = 4'd9,
      OP_CLR_ALARM = 4'd10
   } opcode_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_AUTO     = 2'd0,
      MODE_MANUAL   = 2'd1,
      MODE_OVERRIDE = 2'd2
   } mode_type;

endpackage

// ===== sv/tank_pump_interlock_controller.sv =====
`timescale 1ns / 1ps
// An accepted item sits in the input register; its result is registered into the result
//    register, where rsp_tvalid rises, as soon as that register is empty or being read.
// Throughput: one item per cycle while rsp_tready stays high; the input register holds one
//    more item while a result waits, the whole event runs in combinational compare/add logic.
// Reset: synchronous, active high; clears pump state, alarms, counters, timestamps, loads the
//    default thresholds and empties both channels.
`include "tank_pump_interlock_controller_assert.svh"

module tank_pump_interlock_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [3:0] opcode, [35:4] now_ms, [45:36] level, rest zero
   input  logic [tpic_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] pump_running, [2:1] mode_now, [3] dry_run_alarm, [4] overflow_alarm,
   // [5] rapid_cycle_alarm, [21:6] start_count, [53:22] total_run_ms,
   // [85:54] current_run_ms, rest zero
   output logic [tpic_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [tpic_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tpic_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tpic_pkg::*;

   // configuration
   logic [LEVEL_W-1:0] upper_ff, lower_ff, overflow_ff, max_start_ff;
   logic [MS_W-1:0]    min_off_ff, min_run_ff;
   logic [WIN_W-1:0]   window_ff;

   // input register
   logic               in_valid_ff;
   logic [OP_W-1:0]    in_op_ff;
   logic [TIME_W-1:0]  in_now_ff;
   logic [LEVEL_W-1:0] in_level_ff;

   // controller state; last_on_time always equals run_start, so one register holds both
   logic                pump_ff, pump_in;
   logic                off_seen_ff, off_seen_in;
   mode_type            mode_ff, mode_in;
   logic [TIME_W-1:0]   run_start_ff, run_start_in;
   logic [TIME_W-1:0]   last_off_ff, last_off_in;
   logic [TIME_W-1:0]   acc_ff, acc_in;
   logic [STARTS_W-1:0] starts_ff, starts_in;
   logic                dry_ff, dry_in;
   logic                ovf_ff, ovf_in;
   logic                rapid_ff, rapid_in;
   logic                armed_ff, armed_in;
   logic [TIME_W-1:0]   chk_time_ff, chk_time_in;
   logic [LEVEL_W-1:0]  chk_level_ff, chk_level_in;

   logic                start_w, stop_w;
   logic [TIME_W-1:0]   cur_w, total_w;

   // result register
   logic                out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      logic                try_on, try_off, force_on, force_off, safety_stop, ok;
      logic [LEVEL_W-1:0]  start_lvl;
      logic [TIME_W-1:0]   since_chk, since_off, since_run;

      try_on      = 1'b0;
      try_off     = 1'b0;
      force_on    = 1'b0;
      force_off   = 1'b0;
      safety_stop = 1'b0;
      ok          = 1'b0;
      start_lvl   = '0;

      pump_in      = pump_ff;
      off_seen_in  = off_seen_ff;
      mode_in      = mode_ff;
      run_start_in = run_start_ff;
      last_off_in  = last_off_ff;
      acc_in       = acc_ff;
      starts_in    = starts_ff;
      dry_in       = dry_ff;
      ovf_in       = ovf_ff;
      rapid_in     = rapid_ff;
      armed_in     = armed_ff;
      chk_time_in  = chk_time_ff;
      chk_level_in = chk_level_ff;
      start_w      = 1'b0;
      stop_w       = 1'b0;

      since_chk = in_now_ff - chk_time_ff;

      case (opcode_type'(in_op_ff))
         OP_SAMPLE: begin
            if (mode_ff != MODE_OVERRIDE) begin
               if (pump_ff) begin
                  if (!armed_ff) begin
                     armed_in     = 1'b1;
                     chk_time_in  = in_now_ff;
                     chk_level_in = in_level_ff;
                  end else if (since_chk > {{(TIME_W-WIN_W){1'b0}}, window_ff}) begin
                     if ({1'b0, in_level_ff} < {1'b0, chk_level_ff} + RISE_MIN) begin
                        dry_in      = 1'b1;
                        safety_stop = 1'b1;
                     end
                     armed_in = 1'b0;
                  end
               end else begin
                  armed_in = 1'b0;
               end
               if (in_level_ff >= overflow_ff) begin
                  ovf_in = 1'b1;
                  if (pump_ff) safety_stop = 1'b1;
               end else if ({1'b0, in_level_ff} + OVF_MARGIN < {1'b0, overflow_ff}) begin
                  ovf_in = 1'b0;
               end
               if (safety_stop) begin
                  acc_in      = acc_ff + (in_now_ff - run_start_ff);
                  pump_in     = 1'b0;
                  last_off_in = in_now_ff;
                  off_seen_in = 1'b1;
               end
            end
            if (mode_ff == MODE_AUTO) begin
               if (in_level_ff <= lower_ff && !pump_in) begin
                  try_on    = 1'b1;
                  start_lvl = in_level_ff;
               end else if (in_level_ff >= upper_ff && pump_in) begin
                  try_off = 1'b1;
               end
            end
         end
         OP_REQ_ON:    try_on    = 1'b1;
         OP_REQ_OFF:   try_off   = 1'b1;
         OP_FORCE_ON:  force_on  = 1'b1;
         OP_FORCE_OFF: force_off = 1'b1;
         OP_TOGGLE: begin
            if (mode_ff == MODE_MANUAL) begin
               try_on  = !pump_ff;
               try_off = pump_ff;
            end
         end
         OP_AUTO:     mode_in = MODE_AUTO;
         OP_MANUAL:   mode_in = MODE_MANUAL;
         OP_OVR_ENTER: begin
            mode_in  = MODE_OVERRIDE;
            dry_in   = 1'b0;
            ovf_in   = 1'b0;
            rapid_in = 1'b0;
            armed_in = 1'b0;
         end
         OP_OVR_EXIT: mode_in = MODE_AUTO;
         OP_CLR_ALARM: begin
            dry_in   = 1'b0;
            ovf_in   = 1'b0;
            rapid_in = 1'b0;
            armed_in = 1'b0;
         end
         default: ;
      endcase

      // start and stop gates, evaluated on the state left by the safety checks
      since_off = in_now_ff - last_off_in;
      since_run = in_now_ff - run_start_in;

      if (try_on && !pump_in) begin
         ok = 1'b1;
         if (mode_ff != MODE_OVERRIDE) begin
            if (ovf_in) begin
               ok = 1'b0;
            end else if (start_lvl >= max_start_ff) begin
               ok = 1'b0;
            end else if (off_seen_in
                         && since_off < {{(TIME_W-MS_W){1'b0}}, min_off_ff}) begin
               rapid_in = 1'b1;
               ok       = 1'b0;
            end else begin
               rapid_in = 1'b0;
               if (dry_in) ok = 1'b0;
            end
         end
         start_w = ok;
      end
      if (try_off && pump_in) begin
         stop_w = (mode_ff == MODE_OVERRIDE)
                  || (since_run >= {{(TIME_W-MS_W){1'b0}}, min_run_ff});
      end
      if (force_on) start_w = 1'b1;
      if (force_off) stop_w = 1'b1;

      if (start_w) begin
         pump_in      = 1'b1;
         run_start_in = in_now_ff;
         starts_in    = starts_ff + 1'b1;
      end
      if (stop_w) begin
         if (pump_in) acc_in = acc_in + since_run;
         pump_in     = 1'b0;
         last_off_in = in_now_ff;
         off_seen_in = 1'b1;
      end

      cur_w   = pump_in ? (in_now_ff - run_start_in) : '0;
      total_w = acc_in + cur_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= UPPER_RST;
         lower_ff     <= LOWER_RST;
         overflow_ff  <= OVERFLOW_RST;
         max_start_ff <= MAX_START_RST;
         min_off_ff   <= MIN_OFF_RST;
         min_run_ff   <= MIN_RUN_RST;
         window_ff    <= WINDOW_RST;
      end else if (csr_we) begin
         case (csr_addr_type'(csr_addr))
            CSR_UPPER:     upper_ff     <= csr_wdata[LEVEL_W-1:0];
            CSR_LOWER:     lower_ff     <= csr_wdata[LEVEL_W-1:0];
            CSR_OVERFLOW:  overflow_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_MAX_START: max_start_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_MIN_OFF:   min_off_ff   <= csr_wdata[MS_W-1:0];
            CSR_MIN_RUN:   min_run_ff   <= csr_wdata[MS_W-1:0];
            CSR_WINDOW:    window_ff    <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_op_ff    <= req_tdata[OP_W-1:0];
         in_now_ff   <= req_tdata[OP_W+TIME_W-1:OP_W];
         in_level_ff <= req_tdata[OP_W+TIME_W+LEVEL_W-1:OP_W+TIME_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_ff      <= 1'b0;
         off_seen_ff  <= 1'b0;
         mode_ff      <= MODE_AUTO;
         run_start_ff <= '0;
         last_off_ff  <= '0;
         acc_ff       <= '0;
         starts_ff    <= '0;
         dry_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rapid_ff     <= 1'b0;
         armed_ff     <= 1'b0;
         chk_time_ff  <= '0;
         chk_level_ff <= '0;
      end else if (advance) begin
         pump_ff      <= pump_in;
         off_seen_ff  <= off_seen_in;
         mode_ff      <= mode_in;
         run_start_ff <= run_start_in;
         last_off_ff  <= last_off_in;
         acc_ff       <= acc_in;
         starts_ff    <= starts_in;
         dry_ff       <= dry_in;
         ovf_ff       <= ovf_in;
         rapid_ff     <= rapid_in;
         armed_ff     <= armed_in;
         chk_time_ff  <= chk_time_in;
         chk_level_ff <= chk_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_data_ff <= {2'b00, cur_w, total_w, starts_in, rapid_in, ovf_in, dry_in,
                         mode_in, pump_in};
      end
   end

   `TPIC_ASSERT_SAME(a_start_stop_excl, advance, !(start_w && stop_w))
   `TPIC_ASSERT_SAME(a_override_quiet, mode_ff == MODE_OVERRIDE,
      !armed_ff && !dry_ff && !ovf_ff && !rapid_ff)
   `TPIC_ASSERT_NEXT(a_start_counts, advance && start_w,
      starts_ff == $past(starts_ff) + 1'b1)
   `TPIC_ASSERT_NEXT(a_result_follows, advance, rsp_tvalid)
   `TPIC_ASSERT_SAME(a_idle_run_zero, rsp_tvalid && !rsp_tdata[0], rsp_tdata[85:54] == '0)

endmodule

// ===== sim/tpic_status_checker.sv =====
`timescale 1ns / 1ps

module tpic_status_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // [3:0] opcode, [35:4] now_ms, [45:36] level
   input  logic [tpic_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] pump_running, [2:1] mode_now, [3] dry_run_alarm, [4] overflow_alarm,
   // [5] rapid_cycle_alarm, [21:6] start_count, [53:22] total_run_ms, [85:54] current_run_ms
   input  logic [tpic_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [tpic_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tpic_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              pending_count,
   output int                              checked_count,
   output int                              dry_seen,
   output int                              ovf_seen,
   output int                              rapid_seen
);
   import tpic_pkg::*;

   typedef struct packed {
      logic                pump;
      logic [MODE_W-1:0]   mode;
      logic                dry;
      logic                ovf;
      logic                rapid;
      logic [STARTS_W-1:0] starts;
      logic [TIME_W-1:0]   total;
      logic [TIME_W-1:0]   current;
   } pump_status_type;

   // thresholds as last written
   logic [LEVEL_W-1:0] upper_lvl, lower_lvl, ovf_lvl, max_start_lvl;
   logic [MS_W-1:0]    min_off, min_run;
   logic [WIN_W-1:0]   dry_window;

   // controller state
   logic               pump_on, off_seen, dry_flag, ovf_flag, rapid_flag, dry_armed;
   mode_type           mode;
   logic [TIME_W-1:0]  run_start, last_on, last_off, run_total, dry_time, now_t;
   logic [LEVEL_W-1:0] dry_level;
   logic [STARTS_W-1:0] starts;

   pump_status_type status_due_q[$];
   int errors = 0;

   function automatic logic [TIME_W-1:0] elapsed(logic [TIME_W-1:0] t);
      return now_t - t;
   endfunction

   // refusal by minimum off time also latches the rapid cycle alarm
   function automatic bit start_allowed(logic [LEVEL_W-1:0] lvl);
      if (mode == MODE_OVERRIDE) return 1'b1;
      if (ovf_flag) return 1'b0;
      if (lvl >= max_start_lvl) return 1'b0;
      if (off_seen && elapsed(last_off) < min_off) begin
         rapid_flag = 1'b1;
         return 1'b0;
      end
      rapid_flag = 1'b0;
      return !dry_flag;
   endfunction

   function automatic bit stop_allowed();
      if (mode == MODE_OVERRIDE) return 1'b1;
      return elapsed(last_on) >= min_run;
   endfunction

   function automatic void drive_pump(bit on, bit force_it);
      if (on == pump_on && !force_it) return;
      if (on) begin
         if (!force_it && !start_allowed('0)) return;
         pump_on   = 1'b1;
         run_start = now_t;
         last_on   = now_t;
         starts    = starts + 1'b1;
      end else begin
         if (!force_it && !stop_allowed()) return;
         if (pump_on) run_total = run_total + elapsed(run_start);
         pump_on  = 1'b0;
         last_off = now_t;
         off_seen = 1'b1;
      end
   endfunction

   function automatic void clear_alarms();
      dry_flag   = 1'b0;
      ovf_flag   = 1'b0;
      rapid_flag = 1'b0;
      dry_armed  = 1'b0;
   endfunction

   function automatic void check_safety(logic [LEVEL_W-1:0] lvl);
      if (mode == MODE_OVERRIDE) return;
      if (pump_on) begin
         if (!dry_armed) begin
            dry_armed = 1'b1;
            dry_time  = now_t;
            dry_level = lvl;
         end else if (elapsed(dry_time) > dry_window) begin
            if (int'(lvl) - int'(dry_level) < int'(RISE_MIN)) begin
               dry_flag = 1'b1;
               drive_pump(1'b0, 1'b1);
            end
            dry_armed = 1'b0;
         end
      end else begin
         dry_armed = 1'b0;
      end
      if (lvl >= ovf_lvl) begin
         ovf_flag = 1'b1;
         if (pump_on) drive_pump(1'b0, 1'b1);
      end else if (int'(lvl) + int'(OVF_MARGIN) < int'(ovf_lvl)) begin
         ovf_flag = 1'b0;
      end
   endfunction

   function automatic void auto_control(logic [LEVEL_W-1:0] lvl);
      if (mode != MODE_AUTO) return;
      if (lvl <= lower_lvl && !pump_on) begin
         if (start_allowed(lvl)) drive_pump(1'b1, 1'b0);
      end else if (lvl >= upper_lvl && pump_on) begin
         if (stop_allowed()) drive_pump(1'b0, 1'b0);
      end
   endfunction

   function automatic void reset_controller();
      upper_lvl     = UPPER_RST;
      lower_lvl     = LOWER_RST;
      ovf_lvl       = OVERFLOW_RST;
      max_start_lvl = MAX_START_RST;
      min_off       = MIN_OFF_RST;
      min_run       = MIN_RUN_RST;
      dry_window    = WINDOW_RST;
      pump_on = 1'b0; off_seen = 1'b0;
      clear_alarms();
      mode = MODE_AUTO;
      run_start = '0; last_on = '0; last_off = '0; run_total = '0;
      dry_time = '0; dry_level = '0; starts = '0; now_t = '0;
   endfunction

   function automatic void write_threshold(logic [CSR_ADDR_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_UPPER:     upper_lvl     = val[LEVEL_W-1:0];
         CSR_LOWER:     lower_lvl     = val[LEVEL_W-1:0];
         CSR_OVERFLOW:  ovf_lvl       = val[LEVEL_W-1:0];
         CSR_MAX_START: max_start_lvl = val[LEVEL_W-1:0];
         CSR_MIN_OFF:   min_off       = val[MS_W-1:0];
         CSR_MIN_RUN:   min_run       = val[MS_W-1:0];
         CSR_WINDOW:    dry_window    = val[WIN_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic pump_status_type apply_pump_event(logic [OP_W-1:0] op,
                                                        logic [TIME_W-1:0] at_ms,
                                                        logic [LEVEL_W-1:0] lvl);
      pump_status_type s;
      now_t = at_ms;
      case (op)
         OP_SAMPLE: begin
            check_safety(lvl);
            auto_control(lvl);
         end
         OP_REQ_ON:    drive_pump(1'b1, 1'b0);
         OP_REQ_OFF:   drive_pump(1'b0, 1'b0);
         OP_FORCE_ON:  drive_pump(1'b1, 1'b1);
         OP_FORCE_OFF: drive_pump(1'b0, 1'b1);
         OP_TOGGLE:    if (mode == MODE_MANUAL) drive_pump(!pump_on, 1'b0);
         OP_AUTO:      mode = MODE_AUTO;
         OP_MANUAL:    mode = MODE_MANUAL;
         OP_OVR_ENTER: begin
            mode = MODE_OVERRIDE;
            clear_alarms();
         end
         OP_OVR_EXIT:  mode = MODE_AUTO;
         OP_CLR_ALARM: clear_alarms();
         default: ;
      endcase
      s.pump    = pump_on;
      s.mode    = mode;
      s.dry     = dry_flag;
      s.ovf     = ovf_flag;
      s.rapid   = rapid_flag;
      s.starts  = starts;
      s.current = pump_on ? elapsed(run_start) : '0;
      s.total   = run_total + s.current;
      return s;
   endfunction

   function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                       logic [TIME_W-1:0] got);
      if (want !== got) begin
         if (errors < 10)
            $display("mismatch in %s of status %0d: expected %0h, got %0h",
                     name, checked_count, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      pump_status_type want;
      if (reset) begin
         reset_controller();
         status_due_q.delete();
      end else begin
         if (csr_we) write_threshold(csr_addr, csr_wdata);
         // results go first: an item accepted now cannot answer in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            if (status_due_q.size() == 0) begin
               if (errors < 10) $display("status arrived with none outstanding: %0h", rsp_tdata);
               errors++;
            end else begin
               want = status_due_q.pop_front();
               check_field("pump_running", want.pump, rsp_tdata[0]);
               check_field("mode_now", want.mode, rsp_tdata[2:1]);
               check_field("dry_run_alarm", want.dry, rsp_tdata[3]);
               check_field("overflow_alarm", want.ovf, rsp_tdata[4]);
               check_field("rapid_cycle_alarm", want.rapid, rsp_tdata[5]);
               check_field("start_count", want.starts, rsp_tdata[21:6]);
               check_field("total_run_ms", want.total, rsp_tdata[53:22]);
               check_field("current_run_ms", want.current, rsp_tdata[85:54]);
               checked_count <= checked_count + 1;
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_pump_event(req_tdata[3:0], req_tdata[35:4], req_tdata[45:36]);
            status_due_q.push_back(want);
            if (want.dry) dry_seen <= dry_seen + 1;
            if (want.ovf) ovf_seen <= ovf_seen + 1;
            if (want.rapid) rapid_seen <= rapid_seen + 1;
         end
      end
      pending_count  <= status_due_q.size();
      mismatch_count <= errors;
   end

endmodule

// ===== sim/tb_tank_pump_interlock_controller.sv =====
`timescale 1ns / 1ps

module tb_tank_pump_interlock_controller;
   import tpic_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd11;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;
   localparam int STALL_NONE   = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_SPARSE = 2;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   csr_addr_type          csr_addr = CSR_UPPER;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count, pending_count, checked_count, dry_seen, ovf_seen, rapid_seen;

   logic [TIME_W-1:0] tank_ms = '0;
   int tank_level = 500;
   int burst_left = 0;
   int events_sent = 0;
   int settings_used = 1;
   int ready_style = STALL_NONE;
   int ready_left = 0;
   int idle_cycles = 0;

   tank_pump_interlock_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tpic_status_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .dry_seen       (dry_seen),
      .ovf_seen       (ovf_seen),
      .rapid_seen     (rapid_seen)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver picks a new random stall habit each time its ready_left countdown runs out
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_style <= $urandom_range(STALL_NONE, STALL_SPARSE);
         ready_left  <= $urandom_range(20, 150);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_style)
         STALL_NONE:   rsp_tready <= 1'b1;
         STALL_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= (ready_left % 4 == 0);
      endcase
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   task automatic send_event(logic [OP_W-1:0] op, logic [TIME_W-1:0] at_ms,
                             logic [LEVEL_W-1:0] lvl);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= {2'b00, lvl, at_ms, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      events_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_csr(csr_addr_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_thresholds(int up, int lo, int ovf, int mx, int off_ms, int run_ms,
                                   int win_ms);
      write_csr(CSR_UPPER, CSR_DATA_W'(up));
      write_csr(CSR_LOWER, CSR_DATA_W'(lo));
      write_csr(CSR_OVERFLOW, CSR_DATA_W'(ovf));
      write_csr(CSR_MAX_START, CSR_DATA_W'(mx));
      write_csr(CSR_MIN_OFF, CSR_DATA_W'(off_ms));
      write_csr(CSR_MIN_RUN, CSR_DATA_W'(run_ms));
      write_csr(CSR_WINDOW, CSR_DATA_W'(win_ms));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // timestamps mostly creep forward; now and then they leap anywhere
   task automatic advance_tank();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) tank_ms = tank_ms + $urandom_range(0, 200);
      else if (pick < 65) tank_ms = tank_ms + $urandom_range(0, 60000);
      else if (pick < 90) tank_ms = tank_ms + $urandom_range(0, 400000);
      else if (pick < 97) tank_ms = tank_ms + $urandom_range(0, 4000000);
      else tank_ms = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 88) tank_level = tank_level + int'($urandom_range(0, 120)) - 60;
      else tank_level = $urandom_range(0, 1000);
      if (tank_level < 0) tank_level = 0;
      if (tank_level > 1000) tank_level = 1000;
   endtask

   task automatic random_events(int count);
      logic [OP_W-1:0] op;
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) op = OP_SAMPLE;
         else if (pick < 62) op = OP_AUTO;
         else if (pick < 96) op = OP_W'($urandom_range(OP_REQ_ON, OP_CLR_ALARM));
         else op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         advance_tank();
         send_event(op, tank_ms, LEVEL_W'(tank_level));
      end
   endtask

   task automatic directed_events();
      send_event(OP_SAMPLE, 32'd0, 10'd0);           // first start, no stop seen yet
      send_event(OP_REQ_OFF, 32'd1000, 10'd0);       // held by min run time
      send_event(OP_SAMPLE, 32'd40000, 10'd1000);    // overflow forces the pump off
      send_event(OP_REQ_ON, 32'd41000, 10'd0);
      send_event(OP_SAMPLE, 32'd42000, 10'd925);     // inside release margin
      send_event(OP_CLR_ALARM, 32'd43000, 10'd0);
      send_event(OP_REQ_ON, 32'd44000, 10'd0);       // min off time -> rapid alarm
      send_event(OP_FORCE_ON, 32'd45000, 10'd0);
      send_event(OP_FORCE_ON, 32'd46000, 10'd0);     // restart while running
      send_event(OP_FORCE_OFF, 32'd47000, 10'd0);
      send_event(OP_FORCE_OFF, 32'd48000, 10'd0);    // already stopped
      send_event(OP_MANUAL, 32'd49000, 10'd0);
      send_event(OP_TOGGLE, 32'd90000, 10'd0);
      send_event(OP_TOGGLE, 32'd95000, 10'd0);
      send_event(OP_TOGGLE, 32'd130000, 10'd0);
      send_event(OP_OVR_ENTER, 32'd131000, 10'd0);
      send_event(OP_REQ_ON, 32'd131500, 10'd0);
      send_event(OP_SAMPLE, 32'd132000, 10'd1000);   // override skips safety
      send_event(OP_REQ_OFF, 32'd132500, 10'd0);
      send_event(OP_OVR_EXIT, 32'd133000, 10'd0);
      send_event(OP_AUTO, 32'd133500, 10'd0);
      send_event(OP_UNUSED_LO, 32'd134000, 10'd512);
      send_event(OP_UNUSED_HI, 32'd134500, 10'd1000);
      send_event(OP_SAMPLE, 32'd200000, 10'd100);
      send_event(OP_SAMPLE, 32'd210000, 10'd100);    // arms dry-run check
      send_event(OP_SAMPLE, 32'd600000, 10'd105);    // too little rise
      send_event(OP_SAMPLE, 32'hFFFF_FFFF, 10'd300);
      send_event(OP_SAMPLE, 32'h0000_0100, 10'd300); // timestamp wrapped
      tank_ms = 32'h0000_0100;
   endtask

   initial begin
      int lo, up, ovf;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_events();
      random_events(150);

      drain();
      apply_thresholds(0, 0, 0, 0, 0, 0, 0);
      random_events(150);

      drain();
      apply_thresholds(1000, 1000, 1000, 1000, 3600000, 3600000, 86400000);
      random_events(150);

      repeat (3) begin
         drain();
         lo  = $urandom_range(0, 600);
         up  = $urandom_range(lo, 1000);
         ovf = $urandom_range(up, 1000);
         apply_thresholds(up, lo, ovf, $urandom_range(0, 1000), $urandom_range(0, 120000),
                          $urandom_range(0, 120000), $urandom_range(0, 600000));
         tank_ms = 32'hFFFF_F000 - $urandom_range(0, 400000);
         random_events(150);
      end

      drain();
      repeat (4) @(posedge clock);
      $display("%0d events over %0d threshold settings, %0d statuses checked",
               events_sent, settings_used, checked_count);
      $display("alarm statuses predicted: dry run %0d, overflow %0d, rapid cycle %0d",
               dry_seen, ovf_seen, rapid_seen);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d statuses outstanding", mismatch_count, pending_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== tank_pump_interlock_controller.f =====
+incdir+sv
sv/tpic_pkg.sv
sv/tank_pump_interlock_controller.sv
sim/tpic_status_checker.sv
sim/tb_tank_pump_interlock_controller.sv
